@@ hdl/vnra_pkg.sv @@
package vnra_pkg;

  localparam int Q_W        = 32;
  localparam int FRAC_W     = 16;
  localparam int SIZE_W     = 2;
  localparam int VEC_N      = 3;
  localparam int NAME_IN_W  = 64;
  localparam int PROD_W     = 2 * Q_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int ROUND_HALF = 32768;

  localparam int S_USER_W   = 3;
  localparam int S_DATA_W   = 264;
  localparam int OFF_NAME_B = NAME_IN_W;
  localparam int OFF_DIM    = 2 * NAME_IN_W;
  localparam int OFF_X      = OFF_DIM + SIZE_W;
  localparam int OFF_Y      = OFF_X + Q_W;
  localparam int OFF_Z      = OFF_Y + Q_W;
  localparam int OFF_K      = OFF_Z + Q_W;

  localparam int M_USER_W   = 2;
  localparam int M_DATA_W   = 104;
  localparam int M_PAD_W    = M_DATA_W - SIZE_W - VEC_N * Q_W;

  localparam logic [SIZE_W-1:0] DIM_NONE = 2'd0;
  localparam logic [SIZE_W-1:0] DIM_ONE  = 2'd1;
  localparam logic [SIZE_W-1:0] DIM_FULL = 2'd3;

  typedef logic signed [Q_W-1:0] q_t;
  typedef q_t [VEC_N-1:0] vec_t;

  typedef enum logic [2:0] {
    ACT_STORE = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_SUB   = 3'd2,
    ACT_DOT   = 3'd3,
    ACT_CROSS = 3'd4,
    ACT_SCALE = 3'd5,
    ACT_CLEAR = 3'd6,
    ACT_NOP   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_DIM_MISMATCH = 2'd2,
    ST_FULL         = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_ALU,
    S_RESULT
  } ctl_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_ACC,
    A_RND
  } alu_phase_t;

  typedef enum logic [1:0] {
    MOP_SCALE,
    MOP_DOT,
    MOP_CROSS
  } mul_op_t;

  typedef struct packed {
    logic    start;
    mul_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  function automatic q_t sat_q(input logic [Q_W:0] v);
    q_t res;
    if (v[Q_W] == v[Q_W-1]) begin
      res = v[Q_W-1:0];
    end else if (v[Q_W]) begin
      res = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(Q_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

@@ hdl/vnra_table.sv @@
module vnra_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 162
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/vnra_alu.sv @@
module vnra_alu
  import vnra_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_cmd_t cmd,
  input  vec_t     a,
  input  vec_t     b,
  input  q_t       k,
  output alu_sts_t sts,
  output vec_t     r
);

  localparam logic [1:0] LAST_IDX = 2'(VEC_N - 1);

  alu_phase_t phase, phase_next;
  mul_op_t    op_q;
  logic [1:0] elem;
  logic [1:0] term;
  logic       neg_q;
  logic       done;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic       [1:0] idx_j, idx_k;
  q_t               x_sel, y_sel;
  logic             neg_sel;
  logic             last_term, last_elem;
  logic signed [ACC_W-1:0] prod_ext, addend, rnd;
  q_t               rnd_sat;
  logic             mul_en, acc_en, rnd_en;

  always_comb begin
    idx_j = (elem == 2'd0) ? 2'd1 : (elem == 2'd1) ? 2'd2 : 2'd0;
    idx_k = (elem == 2'd0) ? 2'd2 : (elem == 2'd1) ? 2'd0 : 2'd1;
    x_sel     = '0;
    y_sel     = '0;
    neg_sel   = 1'b0;
    last_term = 1'b1;
    last_elem = 1'b1;
    case (op_q)
      MOP_SCALE: begin
        x_sel     = a[elem];
        y_sel     = k;
        last_elem = (elem == LAST_IDX);
      end
      MOP_DOT: begin
        x_sel     = a[term];
        y_sel     = b[term];
        last_term = (term == LAST_IDX);
      end
      MOP_CROSS: begin
        x_sel     = (term == 2'd0) ? a[idx_j] : a[idx_k];
        y_sel     = (term == 2'd0) ? b[idx_k] : b[idx_j];
        neg_sel   = (term != 2'd0);
        last_term = (term == 2'd1);
        last_elem = (elem == LAST_IDX);
      end
      default: begin
        x_sel = '0;
      end
    endcase
  end

  // exact sum, then round half up to q16.16 and clamp
  always_comb begin
    prod_ext = ACC_W'(prod);
    addend   = neg_q ? -prod_ext : prod_ext;
    rnd      = (acc + ACC_W'(ROUND_HALF)) >>> FRAC_W;
    if ((&rnd[ACC_W-1:Q_W-1]) || !(|rnd[ACC_W-1:Q_W-1])) begin
      rnd_sat = rnd[Q_W-1:0];
    end else if (rnd[ACC_W-1]) begin
      rnd_sat = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      rnd_sat = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      A_IDLE: begin
        if (cmd.start) begin
          phase_next = A_MUL;
        end
      end
      A_MUL: begin
        phase_next = A_ACC;
      end
      A_ACC: begin
        phase_next = last_term ? A_RND : A_MUL;
      end
      A_RND: begin
        phase_next = last_elem ? A_IDLE : A_MUL;
      end
      default: begin
        phase_next = A_IDLE;
      end
    endcase
  end

  always_comb begin
    mul_en   = (phase == A_MUL);
    acc_en   = (phase == A_ACC);
    rnd_en   = (phase == A_RND);
    sts.busy = (phase != A_IDLE);
    sts.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= A_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= rnd_en && last_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q <= cmd.op;
      elem <= 2'd0;
      term <= 2'd0;
      acc  <= '0;
      r    <= '0;
    end
    if (mul_en) begin
      prod  <= x_sel * y_sel;
      neg_q <= neg_sel;
    end
    if (acc_en) begin
      acc <= acc + addend;
      if (!last_term) begin
        term <= term + 2'd1;
      end
    end
    if (rnd_en) begin
      r[elem] <= rnd_sat;
      acc     <= '0;
      term    <= 2'd0;
      elem    <= elem + 2'd1;
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> phase == A_MUL && elem == 2'd0 && term == 2'd0 && acc == '0)
    else $error("alu start did not clear the sequencer");

  a_done_after_round: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> phase == A_IDLE && $past(phase) == A_RND)
    else $error("alu done without a final round step");

endmodule

@@ hdl/named_vector_register_alu_top.sv @@
// Named vector ALU. Vectors of one to three Q16.16 elements are kept in a
// single-port-read table memory of TABLE_ENTRIES rows, each keyed by the low
// NAME_BITS bits of a name. One item is worked at a time: after acceptance the
// table is scanned from row 0 up to the last filled row, one memory read per cycle, and
// both names are matched on the same pass. Store, clear, add and subtract then
// go from the scan through a decide step to a result register; scale, dot and
// cross also pass an ALU step on one shared 32x32 multiplier with a product
// register and an accumulator. The result waits in an output register, so
// the next item is taken while it is still unread. The memory needs no
// clearing after reset.
module named_vector_register_alu_top
  import vnra_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int NAME_BITS     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // name_a, name_b, dimension, elem_x, elem_y, elem_z, scale_factor, zero pad
  input  logic [S_DATA_W-1:0] s_tdata,
  // action
  input  logic [S_USER_W-1:0] s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // out_dimension, out_x, out_y, out_z, zero pad
  output logic [M_DATA_W-1:0] m_tdata,
  // status
  output logic [M_USER_W-1:0] m_tuser
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W = NAME_BITS + SIZE_W + VEC_N * Q_W;

  ctl_state_t state, state_next;

  action_t               act;
  logic [NAME_BITS-1:0]  na, nb;
  logic [SIZE_W-1:0]     dim;
  vec_t                  ev;
  q_t                    kf;
  logic [SIZE_W-1:0]     in_dim;

  logic [CNT_W-1:0]      fill_count;
  logic [CNT_W-1:0]      scan_idx;
  logic                  rd_pend;
  logic [IDX_W-1:0]      rd_idx;
  logic                  found_a, found_b;
  logic [IDX_W-1:0]      idx_a;
  logic [SIZE_W-1:0]     size_a, size_b;
  vec_t                  va, vb;

  logic [ENTRY_W-1:0]    rd_data;
  logic [NAME_BITS-1:0]  rd_name;
  logic [SIZE_W-1:0]     rd_size;
  vec_t                  rd_vec;

  logic                  scan_issue;
  logic                  tbl_wr_en;
  logic [ENTRY_W-1:0]    wr_data;

  status_t               dec_status;
  logic [SIZE_W-1:0]     dec_dim;
  vec_t                  dec_vec;
  logic                  dec_wr, dec_append, dec_clear, dec_alu;
  logic [IDX_W-1:0]      dec_wr_addr;
  mul_op_t               dec_op;
  logic [Q_W:0]          addsub [VEC_N];

  alu_cmd_t              alu_cmd;
  alu_sts_t              alu_sts;
  vec_t                  alu_r;

  status_t               res_status;
  logic [SIZE_W-1:0]     res_dim;
  vec_t                  res_vec;
  logic                  res_load_dec, res_load_alu;

  status_t               out_status;
  logic [SIZE_W-1:0]     out_dim;
  vec_t                  out_vec;
  logic                  out_free, out_load;

  assign in_dim  = s_tdata[OFF_DIM +: SIZE_W];
  assign rd_name = rd_data[NAME_BITS-1:0];
  assign rd_size = rd_data[NAME_BITS +: SIZE_W];
  assign rd_vec  = rd_data[NAME_BITS + SIZE_W +: VEC_N * Q_W];
  assign wr_data = {ev, dim, na};

  vnra_table #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (dec_wr_addr),
    .wr_data (wr_data),
    .rd_en   (scan_issue),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  vnra_alu u_alu (
    .clk (clk),
    .rst (rst),
    .cmd (alu_cmd),
    .a   (va),
    .b   (vb),
    .k   (kf),
    .sts (alu_sts),
    .r   (alu_r)
  );

  always_comb begin
    for (int i = 0; i < VEC_N; i++) begin
      if (act == ACT_SUB) begin
        addsub[i] = {va[i][Q_W-1], va[i]} - {vb[i][Q_W-1], vb[i]};
      end else begin
        addsub[i] = {va[i][Q_W-1], va[i]} + {vb[i][Q_W-1], vb[i]};
      end
    end
  end

  always_comb begin
    dec_status  = ST_OK;
    dec_dim     = DIM_NONE;
    dec_vec     = '0;
    dec_wr      = 1'b0;
    dec_wr_addr = idx_a;
    dec_append  = 1'b0;
    dec_clear   = 1'b0;
    dec_alu     = 1'b0;
    dec_op      = MOP_SCALE;
    case (act)
      ACT_STORE: begin
        if (dim == DIM_NONE) begin
          dec_status = ST_DIM_MISMATCH;
        end else if (found_a) begin
          dec_wr  = 1'b1;
          dec_dim = dim;
          dec_vec = ev;
        end else if (fill_count == CNT_W'(TABLE_ENTRIES)) begin
          dec_status = ST_FULL;
        end else begin
          dec_wr      = 1'b1;
          dec_append  = 1'b1;
          dec_wr_addr = fill_count[IDX_W-1:0];
          dec_dim     = dim;
          dec_vec     = ev;
        end
      end
      ACT_CLEAR: begin
        dec_clear = 1'b1;
      end
      ACT_NOP: begin
        dec_status = ST_OK;
      end
      ACT_SCALE: begin
        if (!found_a) begin
          dec_status = ST_NOT_FOUND;
        end else begin
          dec_alu = 1'b1;
          dec_op  = MOP_SCALE;
          dec_dim = size_a;
        end
      end
      ACT_ADD, ACT_SUB, ACT_DOT, ACT_CROSS: begin
        if (!found_a || !found_b) begin
          dec_status = ST_NOT_FOUND;
        end else if (size_a != size_b || (act == ACT_CROSS && size_a != DIM_FULL)) begin
          dec_status = ST_DIM_MISMATCH;
        end else if (act == ACT_DOT) begin
          dec_alu = 1'b1;
          dec_op  = MOP_DOT;
          dec_dim = DIM_ONE;
        end else if (act == ACT_CROSS) begin
          dec_alu = 1'b1;
          dec_op  = MOP_CROSS;
          dec_dim = DIM_FULL;
        end else begin
          dec_dim = size_a;
          for (int i = 0; i < VEC_N; i++) begin
            dec_vec[i] = sat_q(addsub[i]);
          end
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_issue && !rd_pend) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = dec_alu ? S_ALU : S_RESULT;
      end
      S_ALU: begin
        if (alu_sts.done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_free      = !m_tvalid || m_tready;
    s_tready      = (state == S_IDLE);
    scan_issue    = (state == S_SCAN) && (scan_idx < fill_count);
    tbl_wr_en     = (state == S_DECIDE) && dec_wr;
    alu_cmd.start = (state == S_DECIDE) && dec_alu;
    alu_cmd.op    = dec_op;
    res_load_dec  = (state == S_DECIDE);
    res_load_alu  = (state == S_ALU) && alu_sts.done;
    out_load      = (state == S_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      rd_pend    <= 1'b0;
      found_a    <= 1'b0;
      found_b    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= scan_issue;
      if (s_tvalid && s_tready) begin
        found_a <= 1'b0;
        found_b <= 1'b0;
      end else if (rd_pend) begin
        if (rd_name == na) begin
          found_a <= 1'b1;
        end
        if (rd_name == nb) begin
          found_b <= 1'b1;
        end
      end
      if (state == S_DECIDE) begin
        if (dec_clear) begin
          fill_count <= '0;
        end else if (dec_append) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act      <= action_t'(s_tuser);
      na       <= s_tdata[NAME_BITS-1:0];
      nb       <= s_tdata[OFF_NAME_B +: NAME_BITS];
      dim      <= in_dim;
      ev[0]    <= s_tdata[OFF_X +: Q_W];
      ev[1]    <= (in_dim >= 2'd2) ? q_t'(s_tdata[OFF_Y +: Q_W]) : '0;
      ev[2]    <= (in_dim == DIM_FULL) ? q_t'(s_tdata[OFF_Z +: Q_W]) : '0;
      kf       <= s_tdata[OFF_K +: Q_W];
      scan_idx <= '0;
    end
    if (scan_issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
      rd_idx   <= scan_idx[IDX_W-1:0];
    end
    if (rd_pend && rd_name == na) begin
      idx_a  <= rd_idx;
      size_a <= rd_size;
      va     <= rd_vec;
    end
    if (rd_pend && rd_name == nb) begin
      size_b <= rd_size;
      vb     <= rd_vec;
    end
    if (res_load_dec) begin
      res_status <= dec_status;
      res_dim    <= dec_dim;
      res_vec    <= dec_vec;
    end
    if (res_load_alu) begin
      res_vec <= alu_r;
    end
    if (out_load) begin
      out_status <= res_status;
      out_dim    <= res_dim;
      out_vec    <= res_vec;
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_vec, out_dim};
  assign m_tuser = out_status;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_SCAN && scan_idx == '0 && !found_a && !found_b)
    else $error("scan not restarted on a new item");

  a_write_only_store: assert property (@(posedge clk) disable iff (rst)
    tbl_wr_en |-> act == ACT_STORE && dim != DIM_NONE &&
                  (found_a || fill_count < CNT_W'(TABLE_ENTRIES)))
    else $error("table written outside a valid store");

  a_fill_only_on_decide: assert property (@(posedge clk) disable iff (rst)
    state != S_DECIDE |=> $stable(fill_count))
    else $error("fill count moved outside the decision step");

  a_alu_start_idle: assert property (@(posedge clk) disable iff (rst)
    alu_cmd.start |-> !alu_sts.busy && state == S_DECIDE)
    else $error("alu started while busy");

endmodule
